// ===== rtl/lst_pkg.sv =====
// Shared types and constants for the LRU slot tag store.
// Holds the request and result structs, the command codes and the scan-chain control structs.
// Depends on nothing.
package lst_pkg;

  localparam int NUM_SLOTS_DEF = 64;
  localparam int LAYER_BITS    = 8;
  localparam int EXPERT_BITS   = 10;
  localparam int SLOT_FIELD_W  = 6;
  localparam int STAMP_W       = 32;
  localparam int TALLY_W       = 32;
  localparam int CFG_W         = 7;
  localparam int MIN_SLOTS     = 2;
  localparam int SLOT_NONE     = 0;
  localparam int APB_ADDR_W    = 3;
  localparam int APB_DATA_W    = 32;

  localparam logic [CFG_W-1:0]   SLOTS_RESET = 7'd64;
  localparam logic [STAMP_W-1:0] STAMP_MAX   = '1;

  // Register word index, taken from paddr above the byte offset.
  localparam logic [0:0] REG_SLOTS_IN_USE = 1'b0;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_PROBE = 1'b1
  } cmd_e;

  typedef struct packed {
    cmd_e                   cmd;
    logic [LAYER_BITS-1:0]  layer;
    logic [EXPERT_BITS-1:0] expert;
  } req_t;

  typedef struct packed {
    logic [SLOT_FIELD_W-1:0] slot;
    logic                    hit;
    logic                    load_needed;
    logic [TALLY_W-1:0]      hits_so_far;
    logic [TALLY_W-1:0]      misses_so_far;
  } rsp_t;

  // Control part of the token that walks down the cell chain.
  typedef struct packed {
    logic active;
    logic found;
    logic have_empty;
    logic have_best;
  } scan_flags_t;

  // Write-back broadcast to the cells once a scan is complete.
  typedef struct packed {
    logic key_we;
    logic stamp_we;
  } upd_ctl_t;

endpackage

// ===== rtl/lst_cell.sv =====
// One tag store cell: holds a single entry and forwards the scan token to its neighbor.
// Depends on lst_pkg.
module lst_cell
  import lst_pkg::*;
#(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF,
  parameter int IDX       = 1
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [$clog2(NUM_SLOTS+1)-1:0]   limit,
  input  scan_flags_t                      in_flags,
  input  req_t                             in_req,
  input  logic [$clog2(NUM_SLOTS)-1:0]     in_found_idx,
  input  logic [$clog2(NUM_SLOTS)-1:0]     in_best_idx,
  input  logic [STAMP_W-1:0]               in_best_stamp,
  output scan_flags_t                      out_flags,
  output req_t                             out_req,
  output logic [$clog2(NUM_SLOTS)-1:0]     out_found_idx,
  output logic [$clog2(NUM_SLOTS)-1:0]     out_best_idx,
  output logic [STAMP_W-1:0]               out_best_stamp,
  input  upd_ctl_t                         upd_ctl,
  input  logic [$clog2(NUM_SLOTS)-1:0]     upd_idx,
  input  req_t                             upd_req,
  input  logic [STAMP_W-1:0]               upd_stamp
);

  localparam int SLOT_W = $clog2(NUM_SLOTS);
  localparam int LIM_W  = $clog2(NUM_SLOTS + 1);
  localparam logic [SLOT_W-1:0] MY_IDX = SLOT_W'(IDX);

  logic                   valid;
  logic [LAYER_BITS-1:0]  layer;
  logic [EXPERT_BITS-1:0] expert;
  logic [STAMP_W-1:0]     stamp;

  scan_flags_t        flags_next;
  logic [SLOT_W-1:0]  found_idx_next;
  logic [SLOT_W-1:0]  best_idx_next;
  logic [STAMP_W-1:0] best_stamp_next;
  logic               match;
  logic               in_range;
  logic               upd_sel;

  always_comb begin
    match           = valid && (layer == in_req.layer) && (expert == in_req.expert);
    in_range        = LIM_W'(IDX) < limit;
    flags_next      = in_flags;
    found_idx_next  = in_found_idx;
    best_idx_next   = in_best_idx;
    best_stamp_next = in_best_stamp;
    if (match && !in_flags.found) begin
      flags_next.found = 1'b1;
      found_idx_next   = MY_IDX;
    end
    // Once an empty slot has been seen upstream, it stays the victim.
    if (in_range && !in_flags.have_empty) begin
      if (!valid) begin
        flags_next.have_empty = 1'b1;
        best_idx_next         = MY_IDX;
      end else if (!in_flags.have_best || (stamp < in_best_stamp)) begin
        flags_next.have_best = 1'b1;
        best_idx_next        = MY_IDX;
        best_stamp_next      = stamp;
      end
    end
  end

  assign upd_sel = (upd_idx == MY_IDX);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_flags <= '0;
    end else begin
      out_flags <= flags_next;
    end
  end

  always_ff @(posedge clk) begin
    out_req        <= in_req;
    out_found_idx  <= found_idx_next;
    out_best_idx   <= best_idx_next;
    out_best_stamp <= best_stamp_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (upd_ctl.key_we && upd_sel) begin
      valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_ctl.key_we && upd_sel) begin
      layer  <= upd_req.layer;
      expert <= upd_req.expert;
    end
    if (upd_ctl.stamp_we && upd_sel) begin
      stamp <= upd_stamp;
    end
  end

endmodule

// ===== rtl/lru_slot_tag_store.sv =====
// Top level of the LRU slot tag store: register port, cell chain, write-back and result.
// Depends on lst_pkg and lst_cell.
//
// Usage:
//   A request (cmd, layer, expert) is taken at a clock edge with start high and busy low.
//   It walks down a chain of NUM_SLOTS-1 cells, one cell per cycle; each cell compares
//   its key, and tracks the first empty slot or the oldest stamp among the usable slots.
//   When the token leaves the last cell, an allocate stamps the chosen slot and, on a
//   miss, refills it with the new key and advances the tallies.
//   done is high for exactly one cycle with the result, registered from the token
//   leaving the last cell; the result is taken at the edge that ends that cycle.
//   busy drops in the done cycle, so a new request is taken only once the last one
//   has left the cell chain.
//   The receiver cannot stall the result.
//   slots_in_use sits at byte address 0 of the APB port; write it only while idle.
//   Reset empties every slot and clears the age clock and both tallies; the register
//   returns to 64. No clearing pass is needed.
module lru_slot_tag_store
  import lst_pkg::*;
#(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  req_t                  req,
  output logic                  done,
  output rsp_t                  result,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int SLOT_W = $clog2(NUM_SLOTS);
  localparam int LIM_W  = $clog2(NUM_SLOTS + 1);
  localparam int LAST   = NUM_SLOTS - 1;

  logic [CFG_W-1:0]   slots_in_use;
  logic [LIM_W-1:0]   limit;
  logic [STAMP_W-1:0] age_clock;
  logic [TALLY_W-1:0] hit_tally;
  logic [TALLY_W-1:0] miss_tally;
  logic               busy_next;

  logic               accept;
  logic               cfg_wr;
  logic [0:0]         reg_idx;

  scan_flags_t        chain_flags [NUM_SLOTS];
  req_t               chain_req   [NUM_SLOTS];
  logic [SLOT_W-1:0]  chain_found [NUM_SLOTS];
  logic [SLOT_W-1:0]  chain_best  [NUM_SLOTS];
  logic [STAMP_W-1:0] chain_stamp [NUM_SLOTS];

  scan_flags_t        tail;
  req_t               tail_req;
  logic               fire;
  logic               is_alloc;
  upd_ctl_t           upd_ctl;
  logic [SLOT_W-1:0]  upd_idx;
  logic [SLOT_W-1:0]  slot_pick;
  logic [STAMP_W-1:0] age_next;
  logic [TALLY_W-1:0] hit_tally_next;
  logic [TALLY_W-1:0] miss_tally_next;

  // Register port.
  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    case (reg_idx)
      REG_SLOTS_IN_USE: prdata = APB_DATA_W'(slots_in_use);
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slots_in_use <= SLOTS_RESET;
    end else if (cfg_wr && (reg_idx == REG_SLOTS_IN_USE)) begin
      slots_in_use <= pwdata[CFG_W-1:0];
    end
  end

  // Replacement range, with the register clamped between MIN_SLOTS and the slots that exist.
  always_comb begin
    if (int'(slots_in_use) > NUM_SLOTS) begin
      limit = LIM_W'(NUM_SLOTS);
    end else if (int'(slots_in_use) < MIN_SLOTS) begin
      limit = LIM_W'(MIN_SLOTS);
    end else begin
      limit = LIM_W'(slots_in_use);
    end
  end

  // Token injection at the head of the chain.
  assign accept = start && !busy;

  always_comb begin
    chain_flags[0]        = '0;
    chain_flags[0].active = accept;
    chain_req[0]          = req;
    chain_found[0]        = SLOT_W'(SLOT_NONE);
    chain_best[0]         = SLOT_W'(1);
    chain_stamp[0]        = STAMP_MAX;
  end

  for (genvar i = 1; i < NUM_SLOTS; i++) begin : g_cell
    lst_cell #(
      .NUM_SLOTS (NUM_SLOTS),
      .IDX       (i)
    ) u_cell (
      .clk            (clk),
      .rst            (rst),
      .limit          (limit),
      .in_flags       (chain_flags[i-1]),
      .in_req         (chain_req[i-1]),
      .in_found_idx   (chain_found[i-1]),
      .in_best_idx    (chain_best[i-1]),
      .in_best_stamp  (chain_stamp[i-1]),
      .out_flags      (chain_flags[i]),
      .out_req        (chain_req[i]),
      .out_found_idx  (chain_found[i]),
      .out_best_idx   (chain_best[i]),
      .out_best_stamp (chain_stamp[i]),
      .upd_ctl        (upd_ctl),
      .upd_idx        (upd_idx),
      .upd_req        (tail_req),
      .upd_stamp      (age_next)
    );
  end

  // Decision once the token leaves the last cell.
  always_comb begin
    tail             = chain_flags[LAST];
    tail_req         = chain_req[LAST];
    fire             = tail.active;
    is_alloc         = (tail_req.cmd == CMD_ALLOC);
    age_next         = age_clock + STAMP_W'(1);
    upd_ctl.stamp_we = fire && is_alloc;
    upd_ctl.key_we   = fire && is_alloc && !tail.found;
    upd_idx          = tail.found ? chain_found[LAST] : chain_best[LAST];
    if (tail.found) begin
      slot_pick = chain_found[LAST];
    end else if (is_alloc) begin
      slot_pick = chain_best[LAST];
    end else begin
      slot_pick = SLOT_W'(SLOT_NONE);
    end
    hit_tally_next  = hit_tally;
    miss_tally_next = miss_tally;
    if (fire && is_alloc) begin
      if (tail.found) begin
        hit_tally_next = hit_tally + TALLY_W'(1);
      end else begin
        miss_tally_next = miss_tally + TALLY_W'(1);
      end
    end
  end

  always_comb begin
    busy_next = busy;
    if (accept) begin
      busy_next = 1'b1;
    end else if (fire) begin
      busy_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      done       <= 1'b0;
      age_clock  <= '0;
      hit_tally  <= '0;
      miss_tally <= '0;
    end else begin
      busy       <= busy_next;
      done       <= fire;
      hit_tally  <= hit_tally_next;
      miss_tally <= miss_tally_next;
      if (fire && is_alloc) begin
        age_clock <= age_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result.slot          <= SLOT_FIELD_W'(slot_pick);
      result.hit           <= tail.found;
      result.load_needed   <= is_alloc && !tail.found;
      result.hits_so_far   <= hit_tally_next;
      result.misses_so_far <= miss_tally_next;
    end
  end

endmodule

// ===== rtl/lst_checker.sv =====
// Port-level checks for the LRU slot tag store, attached to the top level by bind.
// Depends on lst_pkg and lru_slot_tag_store.
module lst_port_checker
  import lst_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input rsp_t result
);

  // An accepted request keeps the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after an accepted request");

  // A result only follows a cycle in which a request was in flight.
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a request in flight");

  // The block is free again in the cycle that shows the result.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("busy still high while the result is shown");

  // A refill is requested only on a miss.
  a_load_on_miss: assert property (@(posedge clk) disable iff (rst)
    (done && result.load_needed) |-> !result.hit)
    else $error("load requested for a key that hit");

endmodule

bind lru_slot_tag_store lst_port_checker u_lst_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);

// ===== tb/lst_checker.sv =====
// Checker for the LRU slot tag store: watches the request, result and register channels.
// Keeps its own copy of the tag store, predicts each result and compares it field by field.
// Depends on lst_pkg.
`timescale 1ns / 100ps

module lst_checker
  import lst_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  busy,
  input  req_t                  req,
  input  logic                  done,
  input  rsp_t                  result,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output int                    errors,
  output int                    outstanding
);

  localparam int SLOTS = NUM_SLOTS_DEF;

  logic [CFG_W-1:0]       slot_limit;
  logic                   tag_valid  [SLOTS];
  logic [LAYER_BITS-1:0]  tag_layer  [SLOTS];
  logic [EXPERT_BITS-1:0] tag_expert [SLOTS];
  logic [STAMP_W-1:0]     tag_stamp  [SLOTS];
  logic [STAMP_W-1:0]     age_now;
  logic [TALLY_W-1:0]     hit_count;
  logic [TALLY_W-1:0]     miss_count;
  rsp_t                   slot_answers_q[$];
  rsp_t                   oldest_answer;

  // Looks the key up, applies an allocate to the model and returns the result it gives.
  function automatic rsp_t resolve_key(input req_t r);
    int                 found;
    int                 victim;
    int                 empty;
    int                 limit;
    logic               seen;
    logic [STAMP_W-1:0] oldest;
    rsp_t               a;
    found = SLOT_NONE;
    // Lookups search every valid entry, also those above the current slot limit.
    for (int s = SLOTS - 1; s >= 1; s--)
      if (tag_valid[s] && tag_layer[s] == r.layer && tag_expert[s] == r.expert) found = s;
    a = '0;
    a.hit = (found != SLOT_NONE);
    if (r.cmd == CMD_ALLOC) begin
      age_now = age_now + STAMP_W'(1);
      if (a.hit) begin
        tag_stamp[found] = age_now;
        hit_count = hit_count + TALLY_W'(1);
      end else begin
        limit = int'(slot_limit);
        if (limit < MIN_SLOTS) limit = MIN_SLOTS;
        if (limit > SLOTS) limit = SLOTS;
        empty  = SLOT_NONE;
        victim = 1;
        seen   = 1'b0;
        oldest = STAMP_MAX;
        for (int s = 1; s < limit; s++) begin
          if (empty == SLOT_NONE) begin
            if (!tag_valid[s]) begin
              empty = s;
            end else if (!seen || tag_stamp[s] < oldest) begin
              oldest = tag_stamp[s];
              victim = s;
              seen   = 1'b1;
            end
          end
        end
        if (empty != SLOT_NONE) victim = empty;
        found = victim;
        tag_valid[found]  = 1'b1;
        tag_layer[found]  = r.layer;
        tag_expert[found] = r.expert;
        tag_stamp[found]  = age_now;
        miss_count = miss_count + TALLY_W'(1);
        a.load_needed = 1'b1;
      end
    end
    a.slot          = found[SLOT_FIELD_W-1:0];
    a.hits_so_far   = hit_count;
    a.misses_so_far = miss_count;
    return a;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      slot_limit = SLOTS_RESET;
      for (int s = 0; s < SLOTS; s++) tag_valid[s] = 1'b0;
      age_now    = '0;
      hit_count  = '0;
      miss_count = '0;
      errors     = 0;
      slot_answers_q.delete();
    end else begin
      // A result and a new request can meet at one edge; the result belongs to the older request.
      if (done) begin
        if (slot_answers_q.size() == 0) begin
          errors++;
          $display("%0t: result with no request waiting, actual %0h", $time, result);
        end else begin
          oldest_answer = slot_answers_q.pop_front();
          check_field("slot", 32'(oldest_answer.slot), 32'(result.slot));
          check_field("hit", 32'(oldest_answer.hit), 32'(result.hit));
          check_field("load_needed", 32'(oldest_answer.load_needed),
                      32'(result.load_needed));
          check_field("hits_so_far", oldest_answer.hits_so_far, result.hits_so_far);
          check_field("misses_so_far", oldest_answer.misses_so_far, result.misses_so_far);
        end
      end
      if (start && !busy) slot_answers_q.push_back(resolve_key(req));
      if (psel && penable && pwrite && pready &&
          paddr[APB_ADDR_W-1:2] == REG_SLOTS_IN_USE)
        slot_limit = pwdata[CFG_W-1:0];
    end
    outstanding = slot_answers_q.size();
  end

endmodule

// ===== tb/tb_lru_slot_tag_store.sv =====
// Testbench top for the LRU slot tag store: clock, reset, request and register stimulus.
// Instantiates the block and lst_checker, which predicts and compares; gives the verdict.
// Depends on lst_pkg, lru_slot_tag_store and lst_checker.
`timescale 1ns / 100ps

module tb_lru_slot_tag_store;
  import lst_pkg::*;

  localparam int STALL_LIMIT   = 1000;
  localparam int SETTLE_CYCLES = NUM_SLOTS_DEF + 8;
  localparam int PHASE_ITEMS   = 140;
  localparam int KEY_W         = LAYER_BITS + EXPERT_BITS;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  start;
  logic                  busy;
  req_t                  req_in;
  logic                  done;
  rsp_t                  result;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  int                    errors;
  int                    outstanding;
  int                    quiet_cycles;
  logic [KEY_W-1:0]      key_pool[$];
  bit                    calm;
  bit                    quiet_tail;
  int                    slot_plan[11] = '{2, 0, 1, 127, 64, 5, 100, 17, -1, 3, 64};

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  lru_slot_tag_store u_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .req    (req_in),
    .done   (done),
    .result (result),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  lst_checker u_check (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .req        (req_in),
    .done       (done),
    .result     (result),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .errors     (errors),
    .outstanding(outstanding)
  );

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Called at a falling edge; returns at the falling edge after the request is taken.
  // start stays high so that a request that follows at once needs no second assignment.
  task automatic issue(input cmd_e c, input logic [LAYER_BITS-1:0] l,
                       input logic [EXPERT_BITS-1:0] e);
    req_t r;
    r.cmd    = c;
    r.layer  = l;
    r.expert = e;
    start  <= 1'b1;
    req_in <= r;
    while (busy) @(negedge clk);
    @(negedge clk);
  endtask

  // Sender gap: sometimes counted from the end of the current request, so gaps land late too.
  task automatic rest();
    start <= 1'b0;
    if ($urandom_range(1) == 1) while (busy) @(negedge clk);
    repeat ($urandom_range(13, 1)) @(negedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic write_slots(input logic [CFG_W-1:0] value);
    logic [APB_DATA_W-1:0] word;
    drain();
    word = $urandom();
    word[CFG_W-1:0] = value;
    psel   <= 1'b1;
    pwrite <= 1'b1;
    paddr  <= {REG_SLOTS_IN_USE, 2'b00};
    pwdata <= word;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    while (!pready) @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // Keeps the whole old key set at times, so that entries above a lowered limit still hit.
  task automatic refill_pool(input int usable);
    int               target;
    logic [KEY_W-1:0] k;
    if ($urandom_range(1) == 1) key_pool.delete();
    target = $urandom_range(usable + usable / 2, 1);
    while (key_pool.size() < target) begin
      k = KEY_W'($urandom());
      key_pool.push_back(k);
    end
  endtask

  task automatic run_phase(input int count);
    logic [KEY_W-1:0] k;
    cmd_e             c;
    for (int i = 0; i < count; i++) begin
      if (key_pool.size() == 0 || $urandom_range(9) == 0) k = KEY_W'($urandom());
      else k = key_pool[$urandom_range(key_pool.size() - 1)];
      c = ($urandom_range(4) == 0) ? CMD_PROBE : CMD_ALLOC;
      issue(c, k[KEY_W-1:EXPERT_BITS], k[EXPERT_BITS-1:0]);
      if (!quiet_tail && $urandom_range(39) == 0) calm = !calm;
      if (!calm && $urandom_range(3) == 0) rest();
      if (!quiet_tail && $urandom_range(199) == 0) drain();
    end
  endtask

  initial begin
    int value;
    int usable;
    rst     = 1'b1;
    start   = 1'b0;
    req_in  = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    calm       = 1'b0;
    quiet_tail = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Extreme keys, hits and misses of both commands at the reset slot count.
    issue(CMD_ALLOC, 8'd0, 10'd0);
    issue(CMD_ALLOC, 8'd255, 10'd1023);
    issue(CMD_ALLOC, 8'd255, 10'd0);
    issue(CMD_ALLOC, 8'd0, 10'd1023);
    issue(CMD_ALLOC, 8'h55, 10'h2AA);
    rest();
    issue(CMD_ALLOC, 8'hAA, 10'h155);
    issue(CMD_PROBE, 8'd0, 10'd0);
    issue(CMD_PROBE, 8'd255, 10'd1023);
    issue(CMD_PROBE, 8'd1, 10'd1);
    issue(CMD_ALLOC, 8'd0, 10'd0);
    issue(CMD_ALLOC, 8'd255, 10'd1023);
    issue(CMD_PROBE, 8'hAA, 10'h155);
    // Lowered to the minimum while slots above are in use: only slot 1 is replaced.
    write_slots(7'd2);
    issue(CMD_ALLOC, 8'd7, 10'd7);
    issue(CMD_PROBE, 8'd0, 10'd0);
    issue(CMD_PROBE, 8'd255, 10'd1023);
    issue(CMD_ALLOC, 8'd255, 10'd1023);
    issue(CMD_ALLOC, 8'd0, 10'd0);
    // A count below the minimum and one above the maximum.
    write_slots(7'd0);
    issue(CMD_ALLOC, 8'd9, 10'd9);
    write_slots(7'd127);
    issue(CMD_ALLOC, 8'd1, 10'd2);
    issue(CMD_PROBE, 8'd7, 10'd7);

    for (int p = 0; p < 11; p++) begin
      value = (slot_plan[p] < 0) ? $urandom_range(127) : slot_plan[p];
      write_slots(value[CFG_W-1:0]);
      usable = (value < MIN_SLOTS) ? MIN_SLOTS :
               (value > NUM_SLOTS_DEF) ? NUM_SLOTS_DEF : value;
      refill_pool(usable);
      if (p == 10) begin
        quiet_tail = 1'b1;
        calm       = 1'b1;
      end
      run_phase(PHASE_ITEMS);
    end

    drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/lst_pkg.sv
rtl/lst_cell.sv
rtl/lru_slot_tag_store.sv
rtl/lst_checker.sv
tb/lst_checker.sv
tb/tb_lru_slot_tag_store.sv
